/* design/sws_pkg.sv */
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types and constants of the signed word sorter: controller states and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package sws_pkg;

    localparam int unsigned MAX_WORDS_DEF = 64;
    localparam int unsigned WORD_W        = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEEK,
        ST_CMP,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic cap;       // take the request word, restart read pointer
        logic seek_rd;   // read the entry below the insertion slot
        logic shift;     // move the read entry up one slot
        logic ins_word;  // write the held word into its slot, count it
        logic out_rd;    // read the next sorted entry for output
        logic out_done;  // set emptied, clear the count
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_last;   // last flag of the request on the port
        logic full;      // store holds the maximum number of words
        logic held_last; // held word closes the set
        logic j_zero;    // insertion slot at the bottom
        logic greater;   // entry read is above the held word
        logic k_end;     // output pointer at the final word
    } t_stat;

endpackage

/* design/sws_ctrl.sv */
// ----------------------------------------------------------------------------
// sws_ctrl
// Controller of the signed word sorter: sequences insertion of each word into
// the sorted store and the read-out of a finished set.
// ----------------------------------------------------------------------------
module sws_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  sws_pkg::t_stat i_stat,
    output sws_pkg::t_cmd  o_cmd,
    output logic           busy
);

    sws_pkg::t_state r_state;
    sws_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sws_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sws_pkg::ST_IDLE: begin
                if (start) begin
                    if (!i_stat.full) begin
                        n_state = sws_pkg::ST_SEEK;
                    end else if (i_stat.in_last) begin
                        // dropped word still closes the set
                        n_state = sws_pkg::ST_OUT;
                    end
                end
            end
            sws_pkg::ST_SEEK: begin
                if (i_stat.j_zero) begin
                    n_state = i_stat.held_last ? sws_pkg::ST_OUT : sws_pkg::ST_IDLE;
                end else begin
                    n_state = sws_pkg::ST_CMP;
                end
            end
            sws_pkg::ST_CMP: begin
                if (i_stat.greater) begin
                    n_state = sws_pkg::ST_SEEK;
                end else begin
                    n_state = i_stat.held_last ? sws_pkg::ST_OUT : sws_pkg::ST_IDLE;
                end
            end
            sws_pkg::ST_OUT: begin
                if (i_stat.k_end) begin
                    n_state = sws_pkg::ST_IDLE;
                end
            end
            default: n_state = sws_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            sws_pkg::ST_IDLE: begin
                busy      = 1'b0;
                o_cmd.cap = start;
            end
            sws_pkg::ST_SEEK: begin
                if (i_stat.j_zero) begin
                    o_cmd.ins_word = 1'b1;
                end else begin
                    o_cmd.seek_rd = 1'b1;
                end
            end
            sws_pkg::ST_CMP: begin
                if (i_stat.greater) begin
                    o_cmd.shift = 1'b1;
                end else begin
                    o_cmd.ins_word = 1'b1;
                end
            end
            sws_pkg::ST_OUT: begin
                o_cmd.out_rd   = 1'b1;
                o_cmd.out_done = i_stat.k_end;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

/* design/sws_dp.sv */
// ----------------------------------------------------------------------------
// sws_dp
// Datapath of the signed word sorter: word store kept in ascending order,
// insertion slot pointer, word count, output pointer and result registers.
// ----------------------------------------------------------------------------
module sws_dp #(
    parameter int unsigned MAX_WORDS = sws_pkg::MAX_WORDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [sws_pkg::WORD_W-1:0] i_value,
    input  logic                              i_last,
    input  sws_pkg::t_cmd                     i_cmd,
    output sws_pkg::t_stat                    o_stat,
    output logic                              o_valid,
    output logic signed [sws_pkg::WORD_W-1:0] o_value_res,
    output logic                              o_last_res
);

    localparam int unsigned AW = $clog2(MAX_WORDS);
    localparam int unsigned CW = $clog2(MAX_WORDS + 1);

    logic signed [sws_pkg::WORD_W-1:0] r_mem [MAX_WORDS];

    logic signed [sws_pkg::WORD_W-1:0] r_word;
    logic                              r_last;
    logic signed [sws_pkg::WORD_W-1:0] r_rd;
    logic [AW-1:0]                     r_j;
    logic [AW-1:0]                     r_k;
    logic [CW-1:0]                     r_count;
    logic                              r_strobe;
    logic                              r_out_last;

    logic [AW-1:0]                     rd_addr;
    logic                              rd_en;
    logic                              wr_en;
    logic signed [sws_pkg::WORD_W-1:0] wr_data;

    assign rd_addr = i_cmd.seek_rd ? (r_j - AW'(1)) : r_k;
    assign rd_en   = i_cmd.seek_rd | i_cmd.out_rd;
    assign wr_en   = i_cmd.shift | i_cmd.ins_word;
    assign wr_data = i_cmd.shift ? r_rd : r_word;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_j] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_word <= i_value;
            r_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j        <= '0;
            r_k        <= '0;
            r_count    <= '0;
            r_strobe   <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            r_strobe   <= i_cmd.out_rd;
            r_out_last <= i_cmd.out_rd & o_stat.k_end;
            if (i_cmd.cap) begin
                // slot just above the held words; unused when full
                r_j <= r_count[AW-1:0];
                r_k <= '0;
            end else if (i_cmd.shift) begin
                r_j <= r_j - AW'(1);
            end
            if (i_cmd.out_rd) begin
                r_k <= r_k + AW'(1);
            end
            if (i_cmd.out_done) begin
                r_count <= '0;
            end else if (i_cmd.ins_word) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_comb begin
        o_stat           = '0;
        o_stat.in_last   = i_last;
        o_stat.full      = (r_count == CW'(MAX_WORDS));
        o_stat.held_last = r_last;
        o_stat.j_zero    = (r_j == '0);
        o_stat.greater   = (r_rd > r_word);
        o_stat.k_end     = ((CW'(r_k) + CW'(1)) == r_count);
    end

    assign o_valid     = r_strobe;
    assign o_value_res = r_rd;
    assign o_last_res  = r_out_last;

endmodule

/* design/signed_word_sorter.sv */
// ----------------------------------------------------------------------------
// signed_word_sorter
// Collects a set of signed 32-bit words and returns it in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   A request (value, last) is taken on a rising edge with start high and
//   busy low. Each word is insertion-sorted into the store: busy stays high
//   while the single-port walk down the store reads each held word in turn,
//   compares it with the new word and moves it up one slot if it is above;
//   the walk ends at the first held word not above the new one, or at the
//   bottom slot, and the new word is written into the slot so freed.
//   A request with last high closes the set: once its word is placed, the n
//   held words come out one per cycle on o_value_res, each marked by a
//   one-cycle o_valid strobe, the largest with o_last_res high. Each result
//   is read in the output state and registered; busy falls in the cycle
//   that carries the final result. The receiver cannot hold results off.
//   Words beyond MAX_WORDS in one set are dropped without a busy cycle; a
//   dropped word with last high still closes the set.
//   Synchronous reset empties the set and returns to idle; store contents
//   are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module signed_word_sorter #(
    parameter int unsigned MAX_WORDS = sws_pkg::MAX_WORDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic signed [sws_pkg::WORD_W-1:0] i_value,
    input  logic                              i_last,
    output logic                              busy,
    output logic                              o_valid,
    output logic signed [sws_pkg::WORD_W-1:0] o_value_res,
    output logic                              o_last_res
);

    sws_pkg::t_cmd  cmd;
    sws_pkg::t_stat stat;

    sws_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    sws_dp #(
        .MAX_WORDS (MAX_WORDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_last      (i_last),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_valid     (o_valid),
        .o_value_res (o_value_res),
        .o_last_res  (o_last_res)
    );

    // every result comes from an output read issued the cycle before
    a_valid_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(cmd.out_rd))
        else $error("result strobe without output read");

    // the final flag only rides on a result
    a_last_with_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_res |-> o_valid)
        else $error("last flag without result strobe");

    // shifting and placing the held word never use the write port in the same cycle
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.shift && cmd.ins_word))
        else $error("two store writes in one cycle");

    // after the set is drained the block is ready for a new request
    a_idle_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_done |=> (!busy && o_last_res))
        else $error("not idle after final result");

endmodule

/* verif/tb_signed_word_sorter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_word_sorter
// Feeds sets of signed words to the sorter and checks every sorted word and
// its final flag against a model in the bench that keeps the set and sorts
// it on the closing request. Covers extreme values, duplicates, store
// overflow, random sets with random gaps, a full drain and back-to-back
// traffic.
// ----------------------------------------------------------------------------
module tb_signed_word_sorter;

    localparam int unsigned SET_MAX      = sws_pkg::MAX_WORDS_DEF;
    localparam int          TAIL_CYCLES  = 32;
    localparam int          DRAIN_LIMIT  = 4000;

    typedef logic signed [sws_pkg::WORD_W-1:0] t_word;

    typedef struct {
        t_word value;
        logic  last;
    } t_sorted_word;

    logic  i_clk;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_word i_value = '0;
    logic  i_last  = 1'b0;
    logic  busy;
    logic  o_valid;
    t_word o_value_res;
    logic  o_last_res;

    // words of the set being collected, and sorted words still to come out
    t_word        held_words [$];
    t_sorted_word pending_sorted [$];

    bit gaps_on     = 1'b1;
    int err_count   = 0;
    int req_count   = 0;
    int set_count   = 0;
    int words_seen  = 0;

    signed_word_sorter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_value     (i_value),
        .i_last      (i_last),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_value_res (o_value_res),
        .o_last_res  (o_last_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_signed_word_sorter: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // insertion sort of the held set, queued as the sorted words to come
    function automatic void close_set();
        int    i;
        int    j;
        t_word w;
        t_sorted_word s;
        for (i = 1; i < held_words.size(); i++) begin
            w = held_words[i];
            j = i;
            while (j > 0 && held_words[j-1] > w) begin
                held_words[j] = held_words[j-1];
                j--;
            end
            held_words[j] = w;
        end
        for (i = 0; i < held_words.size(); i++) begin
            s.value = held_words[i];
            s.last  = (i == held_words.size() - 1);
            pending_sorted.push_back(s);
        end
        held_words.delete();
        set_count++;
    endfunction

    function automatic void collect_word(input t_word w, input logic fin);
        if (held_words.size() < SET_MAX)
            held_words.push_back(w);
        if (fin)
            close_set();
    endfunction

    function automatic t_word pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2, 3:    return t_word'($urandom_range(0, 15)) - 8;
            default: return t_word'($urandom);
        endcase
    endfunction

    // one request; start stays high afterwards so the next one can follow
    task automatic send_word(input t_word w, input logic fin);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            i_value <= t_word'($urandom);
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_value <= w;
        i_last  <= fin;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        collect_word(w, fin);
        req_count++;
    endtask

    task automatic send_set(input int size);
        for (int i = 0; i < size; i++)
            send_word(pick_word(), i == size - 1);
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        start <= 1'b0;
        while (pending_sorted.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            words_seen++;
            if (pending_sorted.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d last %0b",
                                          o_value_res, o_last_res));
            end else begin
                if (o_value_res !== pending_sorted[0].value)
                    report_mismatch($sformatf("value %0d, wanted %0d",
                                              o_value_res, pending_sorted[0].value));
                if (o_last_res !== pending_sorted[0].last)
                    report_mismatch($sformatf("last flag %0b, wanted %0b (value %0d)",
                                              o_last_res, pending_sorted[0].last,
                                              pending_sorted[0].value));
                void'(pending_sorted.pop_front());
            end
        end
    end

    task automatic test_directed();
        t_word mixed [7];
        mixed = '{0, -1, 1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                  32'sh5555_5555, 32'shAAAA_AAAA};
        // single-word sets at both ends of the range
        send_word(32'sh8000_0000, 1'b1);
        send_word(32'sh7FFF_FFFF, 1'b1);
        foreach (mixed[i])
            send_word(mixed[i], i == 6);
        // duplicates must all come back
        for (int i = 0; i < 4; i++)
            send_word(5, i == 3);
        // descending input walks the whole store on every insert
        for (int i = 0; i < 5; i++)
            send_word(100 - 50 * i, i == 4);
        for (int i = 0; i < 4; i++)
            send_word(i - 3, i == 3);
    endtask

    task automatic test_store_full();
        // exactly full, then overflow with the closing word dropped
        send_set(SET_MAX);
        send_set(SET_MAX + 3);
    endtask

    task automatic test_random_sets(input int n_req);
        int goal;
        int size;
        goal = req_count + n_req;
        while (req_count < goal) begin
            if ($urandom_range(0, 11) == 0)
                size = $urandom_range(40, SET_MAX + 6);
            else
                size = $urandom_range(1, 10);
            send_set(size);
        end
    endtask

    task automatic test_drain_resume();
        for (int i = 0; i < 4; i++) begin
            send_set($urandom_range(1, 8));
            wait_drained();
        end
    endtask

    task automatic test_back_to_back(input int n_req);
        int goal;
        goal = req_count + n_req;
        gaps_on = 1'b0;
        while (req_count < goal)
            send_set($urandom_range(1, 8));
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_store_full();
        test_random_sets(220);
        test_drain_resume();
        test_back_to_back(60);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_sorted.size() != 0)
            report_mismatch($sformatf("%0d sorted words never came out",
                                      pending_sorted.size()));

        $display("run covered %0d requests in %0d sets, %0d sorted words checked",
                 req_count, set_count, words_seen);
        $display("extremes, duplicates, store overflow, gaps and back-to-back traffic");
        if (err_count == 0) begin
            $display("tb_signed_word_sorter: done, clean");
        end else begin
            $display("tb_signed_word_sorter: done, errors");
        end
        $finish;
    end

endmodule
